FILE: src/mrtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrtm_pkg;

    localparam int TAG_W    = 16;
    localparam int LEN_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int SEQ_W    = 32;
    localparam int PCNT_W   = 5;

    localparam logic [PCNT_W-1:0] PEER_COUNT_RESET = 5'd16;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_RECV = 1'b1;

    typedef enum logic [2:0] {
        OUTCOME_MATCHED    = 3'd0,
        OUTCOME_REC_SPEC   = 3'd1,
        OUTCOME_REC_WILD   = 3'd2,
        OUTCOME_PROBE      = 3'd3,
        OUTCOME_ADDED      = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic commit;
        logic advance;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_add;
        logic is_wild;
        logic start_ok;
        logic hit;
        logic more;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

FILE: src/mrtm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mrtm_ram #(
    parameter int WIDTH = 512,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/mrtm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mrtm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mrtm_pkg::status_t status,
    output mrtm_pkg::cmd_t         cmd
);
    import mrtm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_START;
            ST_START: state_next = status.start_ok ? ST_READ : ST_DONE;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.is_add || status.hit)
                    state_next = ST_DONE;
                else if (status.is_wild && status.more)
                    state_next = ST_READ;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:  if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_START: ;
            ST_READ:  cmd.rd = 1'b1;
            ST_CHECK:
            begin
                cmd.commit  = status.is_add || status.hit;
                cmd.advance = !status.is_add && !status.hit && status.is_wild && status.more;
            end
            ST_DONE:  cmd.out_load = status.out_free;
            default:  ;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/mrtm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mrtm_datapath #(
    parameter int NUM_PEERS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mrtm_pkg::cmd_t                 cmd,
    output mrtm_pkg::status_t                   status,
    input  wire logic                           cfg_we,
    input  wire logic [mrtm_pkg::PCNT_W-1:0]    cfg_data,
    input  wire logic                           operation,
    input  wire logic                           any_source,
    input  wire logic [3:0]                     peer,
    input  wire logic                           any_tag,
    input  wire logic signed [mrtm_pkg::TAG_W-1:0] tag,
    input  wire logic                           is_probe,
    input  wire logic [mrtm_pkg::LEN_W-1:0]     frag_length,
    input  wire logic [mrtm_pkg::HANDLE_W-1:0]  frag_handle,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                matched,
    output logic [2:0]                          outcome,
    output logic                                queue_full,
    output logic [mrtm_pkg::HANDLE_W-1:0]       match_handle,
    output logic [mrtm_pkg::LEN_W-1:0]          match_length,
    output logic signed [mrtm_pkg::TAG_W-1:0]   match_tag,
    output logic [3:0]                          match_source,
    output logic [mrtm_pkg::SEQ_W-1:0]          sequence_res
);
    import mrtm_pkg::*;

    localparam int PW = $clog2(NUM_PEERS);
    localparam int LW = (PW + 1 > PCNT_W) ? PW + 1 : PCNT_W;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ROW_W = QUEUE_DEPTH * ENTRY_W;

    // captured request
    logic              op_reg, wild_reg, any_tag_reg, probe_reg, peer_ok_reg;
    logic [TAG_W-1:0]  tag_reg;
    entry_t            new_entry_reg;
    logic [PW-1:0]     cur_reg;

    logic [PCNT_W-1:0] peer_count_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [FW-1:0]     fill_reg [NUM_PEERS];

    // result being built
    logic              found_reg, added_reg;
    entry_t            res_entry_reg;
    logic [3:0]        res_src_reg;
    logic [SEQ_W-1:0]  res_seq_reg;

    logic [LW-1:0] peer_ext, limit, cur_ext;
    logic          peer_in_range;
    logic [FW-1:0] fill_cur;

    entry_t [QUEUE_DEPTH-1:0] row_rd, row_wr;
    logic [ROW_W-1:0] rdata;
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic [IW-1:0] hit_idx;
    logic hit_any;

    assign peer_ext      = LW'(peer);
    assign peer_in_range = peer_ext < LW'(NUM_PEERS);
    assign cur_ext       = LW'(cur_reg);
    assign limit = (LW'(peer_count_reg) < LW'(NUM_PEERS)) ? LW'(peer_count_reg)
                                                           : LW'(NUM_PEERS);
    assign fill_cur = fill_reg[cur_reg];

    mrtm_ram #(.WIDTH(ROW_W), .DEPTH(NUM_PEERS)) u_rows (
        .clk  (clk),
        .we   (cmd.commit),
        .waddr(cur_reg),
        .wdata(row_wr),
        .re   (cmd.rd),
        .raddr(cur_reg),
        .rdata(rdata)
    );

    assign row_rd = rdata;

    // compare every live entry of the queue at once; oldest hit wins
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit_vec[i] = (FW'(i) < fill_cur) &&
                         (any_tag_reg ? !row_rd[i].tag[TAG_W-1] : row_rd[i].tag == tag_reg);
        end
        hit_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i]) hit_idx = IW'(i);
        end
        hit_any = |hit_vec;
    end

    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (op_reg == OP_ADD)
                row_wr[k] = (FW'(k) == fill_cur) ? new_entry_reg : row_rd[k];
            else if ((IW'(k) >= hit_idx) && (k < QUEUE_DEPTH - 1))
                row_wr[k] = row_rd[(k + 1) % QUEUE_DEPTH];
            else
                row_wr[k] = row_rd[k];
        end
    end

    always_comb
    begin
        status.is_add   = (op_reg == OP_ADD);
        status.is_wild  = wild_reg;
        status.hit      = hit_any;
        status.more     = (cur_ext + LW'(1)) < limit;
        status.out_free = !out_valid || out_ready;
        if (op_reg == OP_ADD)
            status.start_ok = peer_ok_reg && (fill_cur < FW'(QUEUE_DEPTH));
        else if (wild_reg)
            status.start_ok = limit != '0;
        else
            status.start_ok = peer_ok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg               <= operation;
            wild_reg             <= any_source;
            any_tag_reg          <= any_tag;
            probe_reg            <= is_probe;
            peer_ok_reg          <= peer_in_range;
            tag_reg              <= tag;
            new_entry_reg.tag    <= tag;
            new_entry_reg.length <= frag_length;
            new_entry_reg.handle <= frag_handle;
            cur_reg <= (operation == OP_RECV && any_source) ? '0 : peer_ext[PW-1:0];
            res_entry_reg        <= '0;
            res_src_reg          <= '0;
            res_seq_reg          <= (operation == OP_RECV) ? seq_reg : '0;
        end
        else if (cmd.advance)
        begin
            cur_reg <= cur_reg + PW'(1);
        end
        if (cmd.commit && op_reg == OP_RECV)
        begin
            res_entry_reg <= row_rd[hit_idx];
            res_src_reg   <= cur_ext[3:0];
        end
        if (cmd.out_load)
        begin
            matched      <= found_reg;
            queue_full   <= (op_reg == OP_ADD) && !added_reg;
            match_handle <= res_entry_reg.handle;
            match_length <= res_entry_reg.length;
            match_tag    <= res_entry_reg.tag;
            match_source <= res_src_reg;
            sequence_res <= res_seq_reg;
            if (op_reg == OP_ADD)
                outcome <= OUTCOME_ADDED;
            else if (found_reg)
                outcome <= OUTCOME_MATCHED;
            else if (probe_reg)
                outcome <= OUTCOME_PROBE;
            else if (wild_reg)
                outcome <= OUTCOME_REC_WILD;
            else
                outcome <= OUTCOME_REC_SPEC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_count_reg <= PEER_COUNT_RESET;
            seq_reg        <= '0;
            found_reg      <= 1'b0;
            added_reg      <= 1'b0;
            out_valid      <= 1'b0;
            for (int p = 0; p < NUM_PEERS; p++)
            begin
                fill_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                peer_count_reg <= cfg_data;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                added_reg <= 1'b0;
                if (operation == OP_RECV)
                    seq_reg <= seq_reg + SEQ_W'(1);
            end
            if (cmd.commit)
            begin
                if (op_reg == OP_ADD)
                begin
                    added_reg         <= 1'b1;
                    fill_reg[cur_reg] <= fill_cur + FW'(1);
                end
                else
                begin
                    found_reg         <= 1'b1;
                    fill_reg[cur_reg] <= fill_cur - FW'(1);
                end
            end
            if (cmd.out_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: src/message_receive_tag_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake             Payload
// in       in_valid / in_ready   operation .. frag_handle (one request word)
// out      out_valid / out_ready matched .. sequence_res (one result word)
// cfg      cfg_we                cfg_data = peer_count
//
// An add reads its peer's queue row, checks it and appends the entry, or is
// dropped unread (queue full or peer out of range); a specific receive
// reads and checks its peer's row, or is dropped for a peer out of range;
// a wild receive scans peer rows in turn, up to min(peer_count, NUM_PEERS)
// of them, until a hit, and none when peer_count is 0. The block returns to
// idle before it accepts the next request. Each queue row is read from
// the row RAM, compared across all its entries in parallel, written back.
// Reset empties all queues (fill counters), clears the sequence counter and
// sets peer_count to 16. The finished word waits in the output register;
// the next request is accepted while it waits.
module message_receive_tag_matcher #(
    parameter int NUM_PEERS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mrtm_pkg::PCNT_W-1:0]       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              operation,
    input  wire logic                              any_source,
    input  wire logic [3:0]                        peer,
    input  wire logic                              any_tag,
    input  wire logic signed [mrtm_pkg::TAG_W-1:0] tag,
    input  wire logic                              is_probe,
    input  wire logic [mrtm_pkg::LEN_W-1:0]        frag_length,
    input  wire logic [mrtm_pkg::HANDLE_W-1:0]     frag_handle,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   matched,
    output logic [2:0]                             outcome,
    output logic                                   queue_full,
    output logic [mrtm_pkg::HANDLE_W-1:0]          match_handle,
    output logic [mrtm_pkg::LEN_W-1:0]             match_length,
    output logic signed [mrtm_pkg::TAG_W-1:0]      match_tag,
    output logic [3:0]                             match_source,
    output logic [mrtm_pkg::SEQ_W-1:0]             sequence_res
);
    import mrtm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequence: accept, decide, then read/compare each queue row in turn
    mrtm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // queue rows, fill counters, sequence counter and result register
    mrtm_datapath #(
        .NUM_PEERS  (NUM_PEERS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .any_source  (any_source),
        .peer        (peer),
        .any_tag     (any_tag),
        .tag         (tag),
        .is_probe    (is_probe),
        .frag_length (frag_length),
        .frag_handle (frag_handle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .matched     (matched),
        .outcome     (outcome),
        .queue_full  (queue_full),
        .match_handle(match_handle),
        .match_length(match_length),
        .match_tag   (match_tag),
        .match_source(match_source),
        .sequence_res(sequence_res)
    );

endmodule
`default_nettype wire
